@@ src/assert_macros.svh @@
// assertion helpers for the receive state parser checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define RSRP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// checked at every edge, reset included
`define RSRP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

@@ src/rsrp_pkg.sv @@
package rsrp_pkg;

	localparam int OUT_DEPTH = 4;
	localparam int PTR_W     = $clog2(OUT_DEPTH);
	localparam int CNT_W     = $clog2(OUT_DEPTH + 1);
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic [7:0] BAD_CODE_RESET = 8'd3;

	localparam logic [3:0] TAG_ID       = 4'd0;
	localparam logic [3:0] TAG_ATYPE    = 4'd1;
	localparam logic [3:0] TAG_ADDR     = 4'd2;
	localparam logic [3:0] TAG_SID      = 4'd3;
	localparam logic [3:0] TAG_BID      = 4'd4;
	localparam logic [3:0] TAG_PA       = 4'd5;
	localparam logic [3:0] TAG_ENC      = 4'd6;
	localparam logic [3:0] TAG_CODEBYTE = 4'd7;
	localparam logic [3:0] TAG_NSUB     = 4'd8;
	localparam logic [3:0] TAG_BISSYNC  = 4'd9;
	localparam logic [3:0] TAG_METALEN  = 4'd10;
	localparam logic [3:0] TAG_METABYTE = 4'd11;
	localparam logic [3:0] TAG_END      = 4'd12;

	localparam logic [3:0] ADDR_BYTES = 4'd6;
	localparam logic [3:0] BID_BYTES  = 4'd3;
	localparam logic [3:0] BIS_BYTES  = 4'd4;

	typedef enum logic [3:0] {
		PH_ID    = 4'd0,
		PH_ATYPE = 4'd1,
		PH_ADDR  = 4'd2,
		PH_SID   = 4'd3,
		PH_BID   = 4'd4,
		PH_PA    = 4'd5,
		PH_ENC   = 4'd6,
		PH_CODE  = 4'd7,
		PH_NSUB  = 4'd8,
		PH_BIS   = 4'd9,
		PH_MLEN  = 4'd10,
		PH_META  = 4'd11,
		PH_DONE  = 4'd12
	} phase_t;

	typedef struct packed {
		logic [3:0]  field_tag;
		logic [47:0] field_value;
		logic [7:0]  subgroup_index;
		logic [7:0]  byte_index;
		logic        parse_status;
		logic        end_of_message;
	} item_t;

	typedef struct packed {
		logic  field_vld;
		item_t field_item;
		logic  end_vld;
		item_t end_item;
	} step_out_t;

endpackage

@@ src/rsrp_fsm.sv @@
module rsrp_fsm #(
	parameter int CODE_BYTES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	input  logic [7:0]         bad_code_state_value,
	output rsrp_pkg::step_out_t result
);
	import rsrp_pkg::*;

	phase_t      phase_q, phase_s, phase_d;
	logic [4:0]  fbc_q, fbc_s, fbc_d;
	logic [47:0] av_q, av_s, av_d;
	logic [7:0]  sg_total_q, sg_total_s, sg_total_d;
	logic [7:0]  sg_cur_q, sg_cur_s, sg_cur_d;
	logic [7:0]  meta_left_q, meta_left_s, meta_left_d;

	logic [2:0]  pos;
	logic [3:0]  pos_inc;
	logic [3:0]  gather_n;
	logic        gather_done;
	logic [47:0] gathered;
	logic [7:0]  sg_inc;
	logic        code_last;

	assign pos       = fbc_q[2:0];
	assign pos_inc   = {1'b0, pos} + 4'd1;
	assign sg_inc    = sg_cur_q + 8'd1;
	assign code_last = ({1'b0, fbc_q} + 6'd1) >= 6'(CODE_BYTES);

	always_comb begin
		case (phase_q)
			PH_ADDR: gather_n = ADDR_BYTES;
			PH_BID:  gather_n = BID_BYTES;
			PH_BIS:  gather_n = BIS_BYTES;
			default: gather_n = BIS_BYTES;
		endcase
		gather_done = pos_inc >= gather_n;
		gathered    = av_q;
		case (pos)
			3'd0:    gathered[7:0]   = av_q[7:0]   | data_byte;
			3'd1:    gathered[15:8]  = av_q[15:8]  | data_byte;
			3'd2:    gathered[23:16] = av_q[23:16] | data_byte;
			3'd3:    gathered[31:24] = av_q[31:24] | data_byte;
			3'd4:    gathered[39:32] = av_q[39:32] | data_byte;
			3'd5:    gathered[47:40] = av_q[47:40] | data_byte;
			default: gathered        = av_q;
		endcase
	end

	// next state
	always_comb begin
		phase_s     = phase_q;
		fbc_s       = fbc_q;
		av_s        = av_q;
		sg_total_s  = sg_total_q;
		sg_cur_s    = sg_cur_q;
		meta_left_s = meta_left_q;
		case (phase_q)
			PH_ID: begin
				phase_s = PH_ATYPE;
			end
			PH_ATYPE: begin
				phase_s = PH_ADDR;
				av_s    = '0;
				fbc_s   = '0;
			end
			PH_SID: begin
				phase_s = PH_BID;
				av_s    = '0;
				fbc_s   = '0;
			end
			PH_ADDR, PH_BID, PH_BIS: begin
				if (gather_done) begin
					fbc_s = '0;
					av_s  = '0;
					case (phase_q)
						PH_ADDR: phase_s = PH_SID;
						PH_BID:  phase_s = PH_PA;
						default: phase_s = PH_MLEN;
					endcase
				end else begin
					av_s  = gathered;
					fbc_s = {2'b00, pos_inc[2:0]};
				end
			end
			PH_PA: begin
				phase_s = PH_ENC;
			end
			PH_ENC: begin
				fbc_s   = '0;
				phase_s = (data_byte == bad_code_state_value) ? PH_CODE : PH_NSUB;
			end
			PH_CODE: begin
				if (code_last) begin
					fbc_s   = '0;
					phase_s = PH_NSUB;
				end else begin
					fbc_s = fbc_q + 5'd1;
				end
			end
			PH_NSUB: begin
				sg_total_s = data_byte;
				sg_cur_s   = '0;
				av_s       = '0;
				fbc_s      = '0;
				phase_s    = (data_byte == 8'd0) ? PH_DONE : PH_BIS;
			end
			PH_MLEN, PH_META: begin
				if ((phase_q == PH_MLEN && data_byte == 8'd0)
						|| (phase_q == PH_META && meta_left_q == 8'd1)) begin
					sg_cur_s = sg_inc;
					phase_s  = (sg_inc >= sg_total_q) ? PH_DONE : PH_BIS;
					av_s     = '0;
					fbc_s    = '0;
				end else if (phase_q == PH_MLEN) begin
					av_s    = {40'd0, data_byte};
					phase_s = PH_META;
				end
				if (phase_q == PH_MLEN) begin
					meta_left_s = data_byte;
				end else begin
					meta_left_s = meta_left_q - 8'd1;
				end
			end
			default: begin
				phase_s = phase_q;
			end
		endcase

		phase_d     = phase_s;
		fbc_d       = fbc_s;
		av_d        = av_s;
		sg_total_d  = sg_total_s;
		sg_cur_d    = sg_cur_s;
		meta_left_d = meta_left_s;
		if (last_byte) begin
			phase_d     = PH_ID;
			fbc_d       = '0;
			av_d        = '0;
			sg_total_d  = '0;
			sg_cur_d    = '0;
			meta_left_d = '0;
		end
	end

	// result words
	always_comb begin
		result            = '0;
		result.field_item.field_value = {40'd0, data_byte};
		case (phase_q)
			PH_ID: begin
				result.field_vld            = 1'b1;
				result.field_item.field_tag = TAG_ID;
			end
			PH_ATYPE: begin
				result.field_vld            = 1'b1;
				result.field_item.field_tag = TAG_ATYPE;
			end
			PH_ADDR: begin
				result.field_vld              = gather_done;
				result.field_item.field_tag   = TAG_ADDR;
				result.field_item.field_value = gathered;
			end
			PH_SID: begin
				result.field_vld            = 1'b1;
				result.field_item.field_tag = TAG_SID;
			end
			PH_BID: begin
				result.field_vld              = gather_done;
				result.field_item.field_tag   = TAG_BID;
				result.field_item.field_value = gathered;
			end
			PH_PA: begin
				result.field_vld            = 1'b1;
				result.field_item.field_tag = TAG_PA;
			end
			PH_ENC: begin
				result.field_vld            = 1'b1;
				result.field_item.field_tag = TAG_ENC;
			end
			PH_CODE: begin
				result.field_vld             = 1'b1;
				result.field_item.field_tag  = TAG_CODEBYTE;
				result.field_item.byte_index = {3'd0, fbc_q};
			end
			PH_NSUB: begin
				result.field_vld            = 1'b1;
				result.field_item.field_tag = TAG_NSUB;
			end
			PH_BIS: begin
				result.field_vld                 = gather_done;
				result.field_item.field_tag      = TAG_BISSYNC;
				result.field_item.field_value    = gathered;
				result.field_item.subgroup_index = sg_cur_q;
			end
			PH_MLEN: begin
				result.field_vld                 = 1'b1;
				result.field_item.field_tag      = TAG_METALEN;
				result.field_item.subgroup_index = sg_cur_q;
			end
			PH_META: begin
				result.field_vld                 = 1'b1;
				result.field_item.field_tag      = TAG_METABYTE;
				result.field_item.subgroup_index = sg_cur_q;
				result.field_item.byte_index     = av_q[7:0] - meta_left_q;
			end
			default: begin
				result.field_vld = 1'b0;
			end
		endcase
		result.end_vld                 = last_byte;
		result.end_item.field_tag      = TAG_END;
		result.end_item.parse_status   = (phase_s != PH_DONE);
		result.end_item.end_of_message = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_ID;
			fbc_q       <= '0;
			av_q        <= '0;
			sg_total_q  <= '0;
			sg_cur_q    <= '0;
			meta_left_q <= '0;
		end else if (step) begin
			phase_q     <= phase_d;
			fbc_q       <= fbc_d;
			av_q        <= av_d;
			sg_total_q  <= sg_total_d;
			sg_cur_q    <= sg_cur_d;
			meta_left_q <= meta_left_d;
		end
	end

endmodule

@@ src/receive_state_record_parser_unit.sv @@
// channel  | direction | handshake          | payload
// input    | in        | in_valid/in_stall  | data_byte, last_byte
// result   | out       | out_valid/out_stall| field_tag, field_value, subgroup_index,
//          |           |                    | byte_index, parse_status, end_of_message
// config   | in        | apb psel/penable   | bad_code_state_value at byte address 0
//
// one byte is taken per cycle; its field and end words land in a 4-entry result queue
// a byte that closes a field and the message makes two words, drained one per cycle
// in_stall rises while the queue has fewer than two free entries
// out_stall holds the head word; bytes keep flowing until in_stall rises
// arst_n clears the parse state and queue and loads the register with 3
module receive_state_record_parser_unit #(
	parameter int CODE_BYTES = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      data_byte,
	input  logic                            last_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [3:0]                      field_tag,
	output logic [47:0]                     field_value,
	output logic [7:0]                      subgroup_index,
	output logic [7:0]                      byte_index,
	output logic                            parse_status,
	output logic                            end_of_message,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rsrp_pkg::PADDR_W-1:0]    paddr,
	input  logic [rsrp_pkg::PDATA_W-1:0]    pwdata,
	output logic [rsrp_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready
);
	import rsrp_pkg::*;

	logic [7:0]       bad_code_q;
	logic             in_accept;
	logic             pop;
	step_out_t        step_res;
	item_t            queue_q [OUT_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] push_n;
	logic [PTR_W-1:0] end_ptr;
	item_t            head;

	assign pready    = 1'b1;
	assign prdata    = paddr[2] ? '0 : {{(PDATA_W-8){1'b0}}, bad_code_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_code_q <= BAD_CODE_RESET;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			bad_code_q <= pwdata[7:0];
		end
	end

	assign in_stall  = count_q >= CNT_W'(OUT_DEPTH - 1);
	assign in_accept = in_valid && !in_stall;

	rsrp_fsm #(
		.CODE_BYTES(CODE_BYTES)
	) u_fsm (
		.clk                  (clk),
		.arst_n               (arst_n),
		.step                 (in_accept),
		.data_byte            (data_byte),
		.last_byte            (last_byte),
		.bad_code_state_value (bad_code_q),
		.result               (step_res)
	);

	assign push_n  = in_accept ? (CNT_W'(step_res.field_vld) + CNT_W'(step_res.end_vld)) : '0;
	assign end_ptr = wr_ptr_q + PTR_W'(step_res.field_vld);
	assign pop     = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (in_accept && step_res.field_vld) begin
			queue_q[wr_ptr_q] <= step_res.field_item;
		end
		if (in_accept && step_res.end_vld) begin
			queue_q[end_ptr] <= step_res.end_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n[PTR_W-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + push_n - CNT_W'(pop);
		end
	end

	assign head           = queue_q[rd_ptr_q];
	assign out_valid      = count_q != '0;
	assign field_tag      = head.field_tag;
	assign field_value    = head.field_value;
	assign subgroup_index = head.subgroup_index;
	assign byte_index     = head.byte_index;
	assign parse_status   = head.parse_status;
	assign end_of_message = head.end_of_message;

endmodule

@@ src/rsrp_checker.sv @@
`include "assert_macros.svh"

module rsrp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [3:0]  field_tag,
	input logic [47:0] field_value,
	input logic [7:0]  subgroup_index,
	input logic [7:0]  byte_index,
	input logic        parse_status,
	input logic        end_of_message
);
	import rsrp_pkg::*;

	`RSRP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(field_tag) && $stable(field_value) && $stable(byte_index), "stalled result word changed")
	`RSRP_ASSERT(a_eom_tag, out_valid && end_of_message == (field_tag != TAG_END) |-> 1'b0, "end flag and end tag disagree")
	`RSRP_ASSERT(a_status_end, out_valid && !end_of_message |-> !parse_status, "status set on a field word")
	`RSRP_ASSERT(a_sg_zero, out_valid && !(field_tag == TAG_BISSYNC || field_tag == TAG_METALEN || field_tag == TAG_METABYTE) |-> subgroup_index == 8'd0, "subgroup index on a non-subgroup word")
	`RSRP_ASSERT_ALWAYS(a_rst_idle, !arst_n |=> !out_valid && !in_stall, "queue not empty in reset")

endmodule

bind receive_state_record_parser_unit rsrp_checker u_rsrp_checker (.*);

@@ test/receive_state_record_parser_unit_test.sv @@
module receive_state_record_parser_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rsrp_pkg::*;

	localparam int CODE_LEN    = 16;
	localparam int CYCLE_LIMIT = 200000;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	logic [7:0]          data_byte = 8'h00;
	logic                last_byte = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [3:0]          field_tag;
	logic [47:0]         field_value;
	logic [7:0]          subgroup_index;
	logic [7:0]          byte_index;
	logic                parse_status;
	logic                end_of_message;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [PADDR_W-1:0]  paddr     = '0;
	logic [PDATA_W-1:0]  pwdata    = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	receive_state_record_parser_unit #(
		.CODE_BYTES(CODE_LEN)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.field_tag(field_tag),
		.field_value(field_value),
		.subgroup_index(subgroup_index),
		.byte_index(byte_index),
		.parse_status(parse_status),
		.end_of_message(end_of_message),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// parser state as tracked by the testbench
	logic [7:0]  cfg_bad_code;
	phase_t      rec_phase;
	logic [4:0]  byte_pos;
	logic [47:0] acc;
	logic [7:0]  sg_total;
	logic [7:0]  sg_cur;
	logic [7:0]  meta_left;

	item_t       pending_fields[$];
	item_t       want;
	logic [7:0]  msg[$];

	int fails         = 0;
	int words_checked = 0;
	int bytes_sent    = 0;
	int messages_sent = 0;
	int code_blocks   = 0;
	int cycles        = 0;
	bit idle_on       = 1'b1;
	bit stall_on      = 1'b1;

	function automatic item_t field_word(logic [3:0] tag, logic [47:0] val, logic [7:0] sg,
		logic [7:0] bi, logic st, logic eom);
		item_t w;
		w.field_tag      = tag;
		w.field_value    = val;
		w.subgroup_index = sg;
		w.byte_index     = bi;
		w.parse_status   = st;
		w.end_of_message = eom;
		return w;
	endfunction

	task automatic clear_parse;
		rec_phase = PH_ID;
		byte_pos  = '0;
		acc       = '0;
		sg_total  = '0;
		sg_cur    = '0;
		meta_left = '0;
	endtask

	function automatic bit gather(logic [7:0] b, int len);
		int pos;
		pos = int'(byte_pos[2:0]);
		acc = acc | ({40'd0, b} << (8 * pos));
		pos++;
		if (pos >= len) begin
			byte_pos = '0;
			return 1'b1;
		end
		byte_pos = 5'(pos);
		return 1'b0;
	endfunction

	task automatic next_subgroup;
		sg_cur    = sg_cur + 8'd1;
		rec_phase = (sg_cur >= sg_total) ? PH_DONE : PH_BIS;
		acc       = '0;
		byte_pos  = '0;
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic last);
		case (rec_phase)
			PH_ID: begin
				pending_fields.push_back(field_word(TAG_ID, {40'd0, b}, 0, 0, 0, 0));
				rec_phase = PH_ATYPE;
			end
			PH_ATYPE: begin
				pending_fields.push_back(field_word(TAG_ATYPE, {40'd0, b}, 0, 0, 0, 0));
				rec_phase = PH_ADDR;
				acc       = '0;
				byte_pos  = '0;
			end
			PH_ADDR: begin
				if (gather(b, 6)) begin
					pending_fields.push_back(field_word(TAG_ADDR, acc, 0, 0, 0, 0));
					acc       = '0;
					rec_phase = PH_SID;
				end
			end
			PH_SID: begin
				pending_fields.push_back(field_word(TAG_SID, {40'd0, b}, 0, 0, 0, 0));
				rec_phase = PH_BID;
				acc       = '0;
				byte_pos  = '0;
			end
			PH_BID: begin
				if (gather(b, 3)) begin
					pending_fields.push_back(field_word(TAG_BID, acc, 0, 0, 0, 0));
					acc       = '0;
					rec_phase = PH_PA;
				end
			end
			PH_PA: begin
				pending_fields.push_back(field_word(TAG_PA, {40'd0, b}, 0, 0, 0, 0));
				rec_phase = PH_ENC;
			end
			PH_ENC: begin
				pending_fields.push_back(field_word(TAG_ENC, {40'd0, b}, 0, 0, 0, 0));
				byte_pos  = '0;
				rec_phase = (b == cfg_bad_code) ? PH_CODE : PH_NSUB;
			end
			PH_CODE: begin
				pending_fields.push_back(field_word(TAG_CODEBYTE, {40'd0, b}, 0,
					{3'd0, byte_pos}, 0, 0));
				if (int'(byte_pos) + 1 >= CODE_LEN) begin
					byte_pos  = '0;
					rec_phase = PH_NSUB;
				end else begin
					byte_pos = byte_pos + 5'd1;
				end
			end
			PH_NSUB: begin
				pending_fields.push_back(field_word(TAG_NSUB, {40'd0, b}, 0, 0, 0, 0));
				sg_total  = b;
				sg_cur    = '0;
				acc       = '0;
				byte_pos  = '0;
				rec_phase = (b == 8'd0) ? PH_DONE : PH_BIS;
			end
			PH_BIS: begin
				if (gather(b, 4)) begin
					pending_fields.push_back(field_word(TAG_BISSYNC, acc, sg_cur, 0, 0, 0));
					acc       = '0;
					rec_phase = PH_MLEN;
				end
			end
			PH_MLEN: begin
				pending_fields.push_back(field_word(TAG_METALEN, {40'd0, b}, sg_cur, 0, 0, 0));
				if (b == 8'd0) begin
					next_subgroup();
				end else begin
					acc       = {40'd0, b};
					meta_left = b;
					rec_phase = PH_META;
				end
			end
			PH_META: begin
				pending_fields.push_back(field_word(TAG_METABYTE, {40'd0, b}, sg_cur,
					acc[7:0] - meta_left, 0, 0));
				meta_left = meta_left - 8'd1;
				if (meta_left == 8'd0) begin
					next_subgroup();
				end
			end
			default: ;
		endcase
		if (last) begin
			pending_fields.push_back(field_word(TAG_END, '0, 0, 0, rec_phase != PH_DONE, 1'b1));
			clear_parse();
		end
	endtask

	task automatic check_field(input string name, input logic [47:0] exp_val,
		input logic [47:0] got);
		if (got !== exp_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_fields.size() == 0) begin
				$error("unexpected word: tag %0d value %0h", field_tag, field_value);
				fails++;
			end else begin
				want = pending_fields.pop_front();
				check_field("field_tag", {44'd0, want.field_tag}, {44'd0, field_tag});
				check_field("field_value", want.field_value, field_value);
				check_field("subgroup_index", {40'd0, want.subgroup_index},
					{40'd0, subgroup_index});
				check_field("byte_index", {40'd0, want.byte_index}, {40'd0, byte_index});
				check_field("parse_status", {47'd0, want.parse_status}, {47'd0, parse_status});
				check_field("end_of_message", {47'd0, want.end_of_message},
					{47'd0, end_of_message});
				words_checked++;
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= stall_on && ($urandom_range(0, 99) < 21);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("receive_state_record_parser_unit test failed");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		@(negedge clk);
		while (idle_on && $urandom_range(0, 99) < 21) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		parse_byte(b, last);
	endtask

	// trailing bytes follow a complete record and are ignored by the parser
	task automatic send_message(input int trailing);
		int n;
		n = msg.size();
		for (int i = 0; i < trailing; i++) msg.push_back(8'($urandom_range(0, 255)));
		for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1);
		bytes_sent += n;
		messages_sent++;
	endtask

	task automatic settle;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_fields.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] a,
		input logic [31:0] d, output logic [31:0] rd);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= a;
		pwdata  <= d;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic write_register(input logic [PADDR_W-1:0] a, input logic [31:0] d);
		logic [31:0] unused;
		apb_access(1'b1, a, d, unused);
	endtask

	task automatic expect_register;
		logic [31:0] rd;
		apb_access(1'b0, '0, '0, rd);
		if (rd[7:0] !== cfg_bad_code) begin
			$error("bad_code_state_value: expected %0h, got %0h", cfg_bad_code, rd[7:0]);
			fails++;
		end
	endtask

	task automatic build_record(input int meta_max);
		logic [7:0] enc;
		int nsub;
		int mlen;
		msg.delete();
		repeat (13) msg.push_back(8'($urandom_range(0, 255)));
		enc = ($urandom_range(0, 3) == 0) ? cfg_bad_code : 8'($urandom_range(0, 255));
		msg.push_back(enc);
		if (enc == cfg_bad_code) begin
			code_blocks++;
			repeat (CODE_LEN) msg.push_back(8'($urandom_range(0, 255)));
		end
		nsub = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 255) : $urandom_range(0, 3);
		msg.push_back(8'(nsub));
		for (int s = 0; s < nsub && msg.size() < 200; s++) begin
			repeat (4) msg.push_back(8'($urandom_range(0, 255)));
			mlen = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, meta_max);
			msg.push_back(8'(mlen));
			repeat (mlen) msg.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic random_message(input int meta_max);
		int kind;
		int cut;
		kind = $urandom_range(0, 9);
		if (kind <= 7) begin
			build_record(meta_max);
			if (kind >= 6 || msg.size() > 100) begin
				cut = $urandom_range(1, (msg.size() > 100) ? 100 : msg.size() - 1);
				while (msg.size() > cut) void'(msg.pop_back());
				send_message(0);
			end else begin
				send_message((kind == 0) ? $urandom_range(1, 4) : 0);
			end
		end else begin
			// noise, with stray end marks in the middle
			msg.delete();
			repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom_range(0, 255)));
			for (int i = 0; i < msg.size(); i++)
				send_byte(msg[i], (i == msg.size() - 1) || ($urandom_range(0, 4) == 0));
			bytes_sent += msg.size();
			messages_sent++;
		end
	endtask

	task automatic test_reset_value;
		expect_register();
	endtask

	task automatic test_directed_records;
		// shortest complete record, no subgroups
		msg = '{8'h00, 8'hff, 8'hff, 8'h00, 8'h80, 8'h01, 8'h7f, 8'hfe,
			8'hff, 8'h00, 8'hff, 8'h80, 8'h00, 8'h00, 8'h00};
		send_message(0);
		msg = '{8'hff};
		send_message(0);
		// cut inside the address
		msg = '{8'h01, 8'h02, 8'h03, 8'h04};
		send_message(0);
	endtask

	task automatic test_register_settings;
		logic [7:0] settings[4];
		settings = '{8'h00, 8'hff, 8'($urandom_range(1, 254)), BAD_CODE_RESET};
		foreach (settings[i]) begin
			settle();
			write_register('0, {24'($urandom), settings[i]});
			cfg_bad_code = settings[i];
			expect_register();
			repeat (8) random_message(4);
		end
		// address past the only register
		settle();
		write_register(PADDR_W'(4), $urandom);
		expect_register();
	endtask

	task automatic test_long_metadata;
		msg.delete();
		repeat (13) msg.push_back(8'($urandom_range(0, 255)));
		msg.push_back(cfg_bad_code);
		repeat (CODE_LEN) msg.push_back(8'($urandom_range(0, 255)));
		msg.push_back(8'd2);
		repeat (4) msg.push_back(8'($urandom_range(0, 255)));
		msg.push_back(8'd255);
		repeat (255) msg.push_back(8'($urandom_range(0, 255)));
		repeat (4) msg.push_back(8'($urandom_range(0, 255)));
		msg.push_back(8'd0);
		code_blocks++;
		send_message(2);
	endtask

	task automatic test_random_traffic;
		while (bytes_sent < 800) random_message(6);
	endtask

	task automatic test_no_idle;
		int target;
		target   = bytes_sent + 150;
		idle_on  = 1'b0;
		stall_on = 1'b0;
		while (bytes_sent < target) random_message(6);
		idle_on  = 1'b1;
		stall_on = 1'b1;
	endtask

	initial begin
		cfg_bad_code = BAD_CODE_RESET;
		clear_parse();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_value();
		test_directed_records();
		test_register_settings();
		test_long_metadata();
		test_random_traffic();
		test_no_idle();

		settle();
		repeat (20) @(posedge clk);
		$display("sent %0d bytes in %0d messages (%0d bad-code blocks), checked %0d words",
			bytes_sent, messages_sent, code_blocks, words_checked);
		if (fails == 0) begin
			$display("receive_state_record_parser_unit test passed");
		end else begin
			$display("receive_state_record_parser_unit test failed");
		end
		$finish;
	end

endmodule
